// ----- src/sha256_pkg.sv -----
`timescale 1ns / 1ps
// sha256_pkg: shared types, constants and round functions of the SHA-256 hasher.
// No dependencies; used by sha256_round_core and sha256_message_hasher.
package sha256_pkg;

	localparam int unsigned ROUNDS    = 64;
	localparam int unsigned BLK_WORDS = 16;
	localparam int unsigned DIG_WORDS = 8;

	localparam logic [7:0] PAD_BYTE  = 8'h80;
	localparam logic [6:0] LEN_LIMIT = 7'd56;
	localparam logic [3:0] LEN_HI_WORD = 4'd14;
	localparam logic [3:0] LEN_LO_WORD = 4'd15;

	localparam logic [31:0] IV_TAB [DIG_WORDS] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	localparam logic [31:0] K_TAB [ROUNDS] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PREP,
		ST_ROUND,
		ST_FOLD,
		ST_EMIT
	} state_t;

	// what follows the block now running
	typedef enum logic [1:0] {
		AFT_IDLE,
		AFT_PAD,
		AFT_LEN,
		AFT_EMIT
	} aft_t;

	typedef struct packed {
		logic init;     // load working words from chain value
		logic step;     // run one round
		logic use_msg;  // round word comes from the block, not the schedule
	} rc_ctl_t;

	function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
		rotr = (x >> n) | (x << (32 - n));
	endfunction

	function automatic logic [31:0] sum_a(input logic [31:0] x);
		sum_a = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
	endfunction

	function automatic logic [31:0] sum_e(input logic [31:0] x);
		sum_e = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
	endfunction

	function automatic logic [31:0] msg_mix15(input logic [31:0] x);
		msg_mix15 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
	endfunction

	function automatic logic [31:0] msg_mix2(input logic [31:0] x);
		msg_mix2 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
	endfunction

	function automatic logic [31:0] f_ch(input logic [31:0] e, input logic [31:0] f,
		input logic [31:0] g);
		f_ch = (e & f) ^ (~e & g);
	endfunction

	function automatic logic [31:0] f_maj(input logic [31:0] a, input logic [31:0] b,
		input logic [31:0] c);
		f_maj = (a & b) ^ (a & c) ^ (b & c);
	endfunction

endpackage

// ----- src/sha256_block_ram.sv -----
`timescale 1ns / 1ps
// sha256_block_ram: 16 x 32-bit message block buffer, byte-lane write, registered read.
// Byte 0 of a word sits in bits 31:24. No package dependency.
module sha256_block_ram (
	input  logic        clk,
	input  logic        wr_en,
	input  logic [5:0]  wr_addr,
	input  logic [7:0]  wr_data,
	input  logic [3:0]  rd_addr,
	output logic [31:0] rd_data
);

	logic [31:0] mem_q [16];
	logic [31:0] rd_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr[5:2]][{~wr_addr[1:0], 3'b000} +: 8] <= wr_data;
		end
		rd_q <= mem_q[rd_addr];
	end

	assign rd_data = rd_q;

endmodule

// ----- src/sha256_round_core.sv -----
`timescale 1ns / 1ps
// sha256_round_core: working words a..h and the 16-word schedule window; one round per step.
// Depends on sha256_pkg.
module sha256_round_core (
	input  logic                 clk,
	input  sha256_pkg::rc_ctl_t  ctl,
	input  logic [5:0]           rnd,
	input  logic [31:0]          msg_word,
	input  logic [31:0]          chain [8],
	output logic [31:0]          work [8]
);

	logic [31:0] work_q [8];
	logic [31:0] win_q [16];
	logic [31:0] wt;
	logic [31:0] t1;
	logic [31:0] t2;

	// win_q[0] is w[t-16], win_q[15] is w[t-1]
	assign wt = ctl.use_msg ? msg_word
		: sha256_pkg::msg_mix2(win_q[14]) + win_q[9]
		+ sha256_pkg::msg_mix15(win_q[1]) + win_q[0];

	assign t1 = work_q[7] + sha256_pkg::sum_e(work_q[4])
		+ sha256_pkg::f_ch(work_q[4], work_q[5], work_q[6])
		+ sha256_pkg::K_TAB[rnd] + wt;
	assign t2 = sha256_pkg::sum_a(work_q[0])
		+ sha256_pkg::f_maj(work_q[0], work_q[1], work_q[2]);

	always_ff @(posedge clk) begin
		if (ctl.init) begin
			for (int i = 0; i < 8; i++) begin
				work_q[i] <= chain[i];
			end
		end else if (ctl.step) begin
			work_q[7] <= work_q[6];
			work_q[6] <= work_q[5];
			work_q[5] <= work_q[4];
			work_q[4] <= work_q[3] + t1;
			work_q[3] <= work_q[2];
			work_q[2] <= work_q[1];
			work_q[1] <= work_q[0];
			work_q[0] <= t1 + t2;
			for (int i = 0; i < 15; i++) begin
				win_q[i] <= win_q[i + 1];
			end
			win_q[15] <= wt;
		end
	end

	assign work = work_q;

endmodule

// ----- src/sha256_message_hasher.sv -----
`timescale 1ns / 1ps
// sha256_message_hasher: top level of the byte-serial SHA-256 hasher.
// Depends on sha256_pkg, sha256_block_ram and sha256_round_core.
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+------------------------------------
//  in      | sink      | in_valid/in_stall  | data_byte[7:0], has_byte, is_last
//  out     | source    | out_valid/out_stall| digest_word[31:0], word_index[2:0], last_word
//
// Blocking: a byte that does not fill a block is taken without holding in_stall. A byte that
//   completes a 64-byte block holds in_stall high after it through the prep, round and
//   chaining-add states, all on the single shared round unit.
// Closing item: one or two blocks that end the message and carry its padding, then eight digest items.
// Reset: arst_n clears the sequencer, counters and loads the initial hash words.
// Stalls: out_stall freezes the current digest item; in_stall is high whenever the
//   sequencer is not idle, so no item is taken while a block or digest is pending.
module sha256_message_hasher (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  data_byte,
	input  logic        has_byte,
	input  logic        is_last,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] digest_word,
	output logic [2:0]  word_index,
	output logic        last_word
);

	sha256_pkg::state_t  state_q, state_d;
	sha256_pkg::aft_t    aft_q;
	sha256_pkg::rc_ctl_t rc_ctl;

	logic [5:0]  rnd_q;        // round counter
	logic [5:0]  fill_q;       // bytes buffered in the current block
	logic [6:0]  data_cnt_q;   // message bytes in the block being hashed (0..64)
	logic        mark_q;       // block carries the 0x80 marker at data_cnt_q
	logic        len_q;        // block carries the bit length in words 14/15
	logic [60:0] total_q;      // message byte count, wraps
	logic [2:0]  out_idx_q;
	logic [31:0] chain_q [8];
	logic [31:0] work [8];

	logic        in_acc;
	logic        out_acc;
	logic        blk_full;
	logic [6:0]  fin_cnt;
	logic [3:0]  rd_addr;
	logic [31:0] rd_data;
	logic [31:0] msg_word;

	assign in_acc   = in_valid && !in_stall;
	assign out_acc  = out_valid && !out_stall;
	assign blk_full = has_byte && (fill_q == 6'd63);
	assign fin_cnt  = {1'b0, fill_q} + 7'(has_byte);

	// ---------------- next state ----------------
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			sha256_pkg::ST_IDLE: begin
				if (in_acc && (blk_full || is_last)) begin
					state_d = sha256_pkg::ST_PREP;
				end
			end
			sha256_pkg::ST_PREP: state_d = sha256_pkg::ST_ROUND;
			sha256_pkg::ST_ROUND: begin
				if (rnd_q == 6'd63) begin
					state_d = sha256_pkg::ST_FOLD;
				end
			end
			sha256_pkg::ST_FOLD: begin
				unique case (aft_q)
					sha256_pkg::AFT_IDLE: state_d = sha256_pkg::ST_IDLE;
					sha256_pkg::AFT_PAD:  state_d = sha256_pkg::ST_PREP;
					sha256_pkg::AFT_LEN:  state_d = sha256_pkg::ST_PREP;
					sha256_pkg::AFT_EMIT: state_d = sha256_pkg::ST_EMIT;
					default:              state_d = sha256_pkg::ST_IDLE;
				endcase
			end
			sha256_pkg::ST_EMIT: begin
				if (out_acc && (out_idx_q == 3'd7)) begin
					state_d = sha256_pkg::ST_IDLE;
				end
			end
			default: state_d = sha256_pkg::ST_IDLE;
		endcase
	end

	// ---------------- outputs of the sequencer ----------------
	always_comb begin
		in_stall       = (state_q != sha256_pkg::ST_IDLE);
		out_valid      = (state_q == sha256_pkg::ST_EMIT);
		rc_ctl.init    = (state_q == sha256_pkg::ST_PREP);
		rc_ctl.step    = (state_q == sha256_pkg::ST_ROUND);
		rc_ctl.use_msg = (rnd_q < 6'd16);
		// prefetch: word r is read in the cycle before round r
		rd_addr        = (state_q == sha256_pkg::ST_ROUND) ? (rnd_q[3:0] + 4'd1) : 4'd0;
	end

	// ---------------- sequencer registers ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= sha256_pkg::ST_IDLE;
			aft_q      <= sha256_pkg::AFT_IDLE;
			rnd_q      <= '0;
			fill_q     <= '0;
			data_cnt_q <= '0;
			mark_q     <= 1'b0;
			len_q      <= 1'b0;
			total_q    <= '0;
			out_idx_q  <= '0;
			for (int i = 0; i < 8; i++) begin
				chain_q[i] <= sha256_pkg::IV_TAB[i];
			end
		end else begin
			state_q <= state_d;
			unique case (state_q)
				sha256_pkg::ST_IDLE: begin
					if (in_acc) begin
						if (has_byte) begin
							total_q <= total_q + 61'd1;
						end
						priority if (blk_full) begin
							// full block first; an end marker gets a padding-only block
							fill_q     <= '0;
							data_cnt_q <= 7'd64;
							mark_q     <= 1'b0;
							len_q      <= 1'b0;
							aft_q      <= is_last ? sha256_pkg::AFT_PAD : sha256_pkg::AFT_IDLE;
						end else if (is_last) begin
							// marker here; length fits only below byte 56
							fill_q     <= '0;
							data_cnt_q <= fin_cnt;
							mark_q     <= 1'b1;
							len_q      <= (fin_cnt < sha256_pkg::LEN_LIMIT);
							aft_q      <= (fin_cnt < sha256_pkg::LEN_LIMIT)
								? sha256_pkg::AFT_EMIT : sha256_pkg::AFT_LEN;
						end else begin
							fill_q <= fill_q + 6'(has_byte);
						end
					end
				end
				sha256_pkg::ST_PREP: rnd_q <= '0;
				sha256_pkg::ST_ROUND: rnd_q <= rnd_q + 6'd1;
				sha256_pkg::ST_FOLD: begin
					for (int i = 0; i < 8; i++) begin
						chain_q[i] <= chain_q[i] + work[i];
					end
					unique case (aft_q)
						sha256_pkg::AFT_PAD: begin
							data_cnt_q <= '0;
							mark_q     <= 1'b1;
							len_q      <= 1'b1;
							aft_q      <= sha256_pkg::AFT_EMIT;
						end
						sha256_pkg::AFT_LEN: begin
							data_cnt_q <= '0;
							mark_q     <= 1'b0;
							len_q      <= 1'b1;
							aft_q      <= sha256_pkg::AFT_EMIT;
						end
						sha256_pkg::AFT_EMIT: begin
							total_q   <= '0;
							out_idx_q <= '0;
							aft_q     <= sha256_pkg::AFT_IDLE;
						end
						default: aft_q <= sha256_pkg::AFT_IDLE;
					endcase
				end
				sha256_pkg::ST_EMIT: begin
					if (out_acc) begin
						// shift the digest out and the initial words in behind it
						for (int i = 0; i < 7; i++) begin
							chain_q[i] <= chain_q[i + 1];
						end
						chain_q[7] <= sha256_pkg::IV_TAB[out_idx_q];
						out_idx_q  <= out_idx_q + 3'd1;
					end
				end
				default: ;
			endcase
		end
	end

	// ---------------- block buffer ----------------
	sha256_block_ram u_ram (
		.clk     (clk),
		.wr_en   (in_acc && has_byte),
		.wr_addr (fill_q),
		.wr_data (data_byte),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	// Padding is formed on the read side: bytes past data_cnt_q are never trusted.
	always_comb begin
		logic [6:0] pos;
		for (int l = 0; l < 4; l++) begin
			pos = {1'b0, rnd_q[3:0], 2'(l)};
			if (pos < data_cnt_q) begin
				msg_word[(3 - l) * 8 +: 8] = rd_data[(3 - l) * 8 +: 8];
			end else if (mark_q && (pos == data_cnt_q)) begin
				msg_word[(3 - l) * 8 +: 8] = sha256_pkg::PAD_BYTE;
			end else begin
				msg_word[(3 - l) * 8 +: 8] = 8'h00;
			end
		end
		if (len_q && (rnd_q[3:0] == sha256_pkg::LEN_HI_WORD)) begin
			msg_word = total_q[60:29];
		end else if (len_q && (rnd_q[3:0] == sha256_pkg::LEN_LO_WORD)) begin
			msg_word = {total_q[28:0], 3'b000};
		end
	end

	// ---------------- shared round unit ----------------
	sha256_round_core u_core (
		.clk      (clk),
		.ctl      (rc_ctl),
		.rnd      (rnd_q),
		.msg_word (msg_word),
		.chain    (chain_q),
		.work     (work)
	);

	assign digest_word = chain_q[0];
	assign word_index  = out_idx_q;
	assign last_word   = (out_idx_q == 3'd7);

`ifndef NO_ASSERTIONS
	// no input is taken while digest words are pending
	a_emit_blocks_in: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> in_stall)
		else $error("input ready while digest pending");

	// a closing item always starts hashing
	a_last_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall && is_last) |=> in_stall)
		else $error("closing item did not start a block");

	// digest words come out in order
	a_word_order: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_stall && !last_word) |=>
		(out_valid && (word_index == $past(word_index) + 3'd1)))
		else $error("digest word order broken");

	// nothing follows the eighth word
	a_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_stall && last_word) |=> !out_valid)
		else $error("extra digest word");
`endif

endmodule
